// ----- rtl/pkhc_pkg.sv -----
// ----------------------------------------------------------------------------
// pkhc_pkg: shared types and constants of the path-keyed hash cache
// Beat structs, status codes, sequencer states and jhash constants.
// ----------------------------------------------------------------------------
package pkhc_pkg;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_PRESENT   = 3'd3,
		ST_FULL      = 3'd4,
		ST_TOO_LONG  = 3'd5
	} status_t;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} opcode_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] key_word;
		logic        last_word;
		logic [31:0] entry_value;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_value;
	} out_beat_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_HCHK, S_HFET, S_HADD, S_HMIX, S_HFIN, S_DIV, S_BASE,
		S_WRD, S_WCHK, S_KRD, S_KCMP, S_DECIDE, S_INS, S_CPRD, S_CPWR, S_RESULT
	} seq_state_t;

	localparam logic [31:0] JH_INIT_SEED = 32'hdeadbeef + 32'd1234;
	localparam logic [6:0]  BIU_RESET    = 7'd64;
	localparam logic        REG_BIU      = 1'b0;

	localparam logic [4:0] MIX_ROT [6] = '{5'd4, 5'd6, 5'd8, 5'd16, 5'd19, 5'd4};
	localparam logic [4:0] FIN_ROT [7] = '{5'd14, 5'd11, 5'd25, 5'd16, 5'd4, 5'd14, 5'd24};

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] t;
		t = {x, x} << r;
		return t[63:32];
	endfunction

endpackage

// ----- rtl/path_keyed_hash_cache_unit.sv -----
// ----------------------------------------------------------------------------
// path_keyed_hash_cache_unit: set-associative table keyed by a path of ids
// Collects key words, hashes with jhash, picks a bucket and looks up or
// inserts over WAYS ways with one shared datapath under a sequencer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) carries one key word per beat;
// the beat with last_word set ends the key and starts the operation.
// Output channel (out_valid/out_stall/out_data) gives one beat per key.
// Non-last words are taken one per cycle while the sequencer is idle. A last
// word then occupies the sequencer: hashing fetches and adds each key word,
// mixes after each block of three words that has more words after it and
// finishes; the bucket is the hash modulo the configured bucket count (one
// quotient bit a cycle); then come the bucket base, the way search reading
// each way and comparing its words, the decision, on insert the entry write
// and the word-by-word key copy, and the load of the output register. The
// registered read of the key memory sets the search pace.
// A too-long key skips hashing and search and goes straight to the result.
// After reset the valid marks of all BUCKETS*WAYS slots are cleared one per
// cycle; in_stall is high meanwhile, configuration is still taken.
// A finished result waits in the output register while out_stall is high;
// further key words are taken, the next result waits for the register.
// ----------------------------------------------------------------------------
module path_keyed_hash_cache_unit #(
	parameter int BUCKETS  = 64,
	parameter int WAYS     = 4,
	parameter int MAX_PATH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pkhc_pkg::in_beat_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output pkhc_pkg::out_beat_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SLOTS = BUCKETS * WAYS;
	localparam int KEYS  = SLOTS * MAX_PATH;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KAW   = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int LW    = $clog2(MAX_PATH + 1);
	localparam int KI    = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MW    = $clog2(BUCKETS) + 2;

	pkhc_pkg::seq_state_t state_q, state_d;

	logic [6:0]    biu_q;
	logic [LW-1:0] wc_q, n_q, i_q, j_q;
	logic          tl_q, op_q, hit_q, free_q, out_valid_q;
	logic [31:0]   hdl_in_q, a_q, b_q, c_q, val_q;
	logic [1:0]    k_q, ph_q;
	logic [2:0]    step_q;
	logic [4:0]    dcnt_q;
	logic [MW-1:0] r_q, mod_q;
	logic [SW-1:0] slot_q, fslot_q, clr_q;
	logic [KAW-1:0] wbase_q, fbase_q;
	logic [WW-1:0] w_q;
	pkhc_pkg::status_t  status_q;
	pkhc_pkg::out_beat_t out_q;

	logic          val_mem [SLOTS];
	logic [LW-1:0] len_mem [SLOTS];
	logic [31:0]   hdl_mem [SLOTS];
	logic [31:0]   key_mem [KEYS];
	logic [31:0]   kb_mem  [MAX_PATH];
	logic          val_rd_q;
	logic [LW-1:0] len_rd_q;
	logic [31:0]   hdl_rd_q, key_rd_q, kb_rd_q;

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == pkhc_pkg::REG_BIU);
	assign prdata = (paddr[2] == pkhc_pkg::REG_BIU) ? {25'd0, biu_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= pkhc_pkg::BIU_RESET;
		end else if (cfg_wr) begin
			biu_q <= pwdata[6:0];
		end
	end

	// effective modulus
	logic [MW-1:0] mod_eff;
	always_comb begin
		if (biu_q == 7'd0) begin
			mod_eff = MW'(1);
		end else if (32'(biu_q) > 32'(BUCKETS)) begin
			mod_eff = MW'(BUCKETS);
		end else begin
			mod_eff = MW'(biu_q);
		end
	end

	logic in_acc, room, too_long, last_acc;
	logic [LW-1:0] n_new, rem, cnt;
	assign in_acc   = in_valid && !in_stall;
	assign room     = wc_q < LW'(MAX_PATH);
	assign too_long = tl_q || !room;
	assign last_acc = in_acc && in_data.last_word;
	assign n_new    = room ? wc_q + LW'(1) : wc_q;
	assign rem      = n_q - i_q;
	assign cnt      = (rem > LW'(3)) ? LW'(3) : rem;

	// shared hash unit
	logic [31:0] a_n, b_n, c_n, rot_y;
	logic [4:0]  rot;
	logic        fin;
	assign fin = (state_q == pkhc_pkg::S_HFIN);
	always_comb begin
		a_n = a_q;
		b_n = b_q;
		c_n = c_q;
		rot = fin ? pkhc_pkg::FIN_ROT[step_q] : pkhc_pkg::MIX_ROT[step_q];
		case (ph_q)
			2'd0: rot_y = fin ? pkhc_pkg::rotl(b_q, rot) : pkhc_pkg::rotl(c_q, rot);
			2'd1: rot_y = fin ? pkhc_pkg::rotl(c_q, rot) : pkhc_pkg::rotl(a_q, rot);
			default: rot_y = fin ? pkhc_pkg::rotl(a_q, rot) : pkhc_pkg::rotl(b_q, rot);
		endcase
		if (fin) begin
			case (ph_q)
				2'd0: c_n = (c_q ^ b_q) - rot_y;
				2'd1: a_n = (a_q ^ c_q) - rot_y;
				default: b_n = (b_q ^ a_q) - rot_y;
			endcase
		end else begin
			case (ph_q)
				2'd0: begin
					a_n = (a_q - c_q) ^ rot_y;
					c_n = c_q + b_q;
				end
				2'd1: begin
					b_n = (b_q - a_q) ^ rot_y;
					a_n = a_q + c_q;
				end
				default: begin
					c_n = (c_q - b_q) ^ rot_y;
					b_n = b_q + a_q;
				end
			endcase
		end
	end

	// restoring modulo step
	logic [MW-1:0] trial, r_n;
	assign trial = {r_q[MW-2:0], c_q[31]};
	assign r_n   = (trial >= mod_q) ? trial - mod_q : trial;

	logic last_way, last_j, len_eq;
	assign last_way = (w_q == WW'(WAYS - 1));
	assign last_j   = (j_q == n_q - LW'(1));
	assign len_eq   = val_rd_q && (len_rd_q == n_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pkhc_pkg::S_CLEAR:  if (clr_q == SW'(SLOTS - 1)) state_d = pkhc_pkg::S_IDLE;
			pkhc_pkg::S_IDLE: begin
				if (last_acc) begin
					state_d = too_long ? pkhc_pkg::S_RESULT : pkhc_pkg::S_HCHK;
				end
			end
			pkhc_pkg::S_HCHK:   state_d = (rem == '0) ? pkhc_pkg::S_DIV : pkhc_pkg::S_HFET;
			pkhc_pkg::S_HFET:   state_d = pkhc_pkg::S_HADD;
			pkhc_pkg::S_HADD: begin
				if (LW'(k_q) + LW'(1) == cnt) begin
					state_d = (rem > LW'(3)) ? pkhc_pkg::S_HMIX : pkhc_pkg::S_HFIN;
				end else begin
					state_d = pkhc_pkg::S_HFET;
				end
			end
			pkhc_pkg::S_HMIX:   if (step_q == 3'd5) state_d = pkhc_pkg::S_HCHK;
			pkhc_pkg::S_HFIN:   if (step_q == 3'd6) state_d = pkhc_pkg::S_DIV;
			pkhc_pkg::S_DIV:    if (dcnt_q == 5'd0) state_d = pkhc_pkg::S_BASE;
			pkhc_pkg::S_BASE:   state_d = pkhc_pkg::S_WRD;
			pkhc_pkg::S_WRD:    state_d = pkhc_pkg::S_WCHK;
			pkhc_pkg::S_WCHK: begin
				if (len_eq) begin
					state_d = pkhc_pkg::S_KRD;
				end else begin
					state_d = last_way ? pkhc_pkg::S_DECIDE : pkhc_pkg::S_WRD;
				end
			end
			pkhc_pkg::S_KRD:    state_d = pkhc_pkg::S_KCMP;
			pkhc_pkg::S_KCMP: begin
				if (key_rd_q != kb_rd_q) begin
					state_d = last_way ? pkhc_pkg::S_DECIDE : pkhc_pkg::S_WRD;
				end else begin
					state_d = last_j ? pkhc_pkg::S_DECIDE : pkhc_pkg::S_KRD;
				end
			end
			pkhc_pkg::S_DECIDE: begin
				state_d = (op_q == pkhc_pkg::OP_INSERT && !hit_q && free_q) ?
					pkhc_pkg::S_INS : pkhc_pkg::S_RESULT;
			end
			pkhc_pkg::S_INS:    state_d = pkhc_pkg::S_CPRD;
			pkhc_pkg::S_CPRD:   state_d = pkhc_pkg::S_CPWR;
			pkhc_pkg::S_CPWR:   state_d = last_j ? pkhc_pkg::S_RESULT : pkhc_pkg::S_CPRD;
			pkhc_pkg::S_RESULT: if (!out_valid_q || !out_stall) state_d = pkhc_pkg::S_IDLE;
			default:            state_d = pkhc_pkg::S_IDLE;
		endcase
	end

	// strobes and addresses
	logic          kb_we, val_we, ent_we, key_we, val_wd;
	logic [SW-1:0] val_wa;
	logic [KI-1:0] kb_ra;
	logic [LW:0]   kb_sum;
	always_comb begin
		kb_we  = in_acc && room;
		val_we = 1'b0;
		val_wd = 1'b0;
		val_wa = fslot_q;
		ent_we = 1'b0;
		key_we = 1'b0;
		kb_sum = {1'b0, j_q};
		case (state_q)
			pkhc_pkg::S_CLEAR: begin
				val_we = 1'b1;
				val_wa = clr_q;
			end
			pkhc_pkg::S_HFET:  kb_sum = {1'b0, i_q} + (LW + 1)'(k_q);
			pkhc_pkg::S_INS: begin
				val_we = 1'b1;
				val_wd = 1'b1;
				ent_we = 1'b1;
			end
			pkhc_pkg::S_CPWR:  key_we = 1'b1;
			default: ;
		endcase
		kb_ra = kb_sum[KI-1:0];
	end

	assign in_stall = (state_q != pkhc_pkg::S_IDLE);

	// memories
	always_ff @(posedge clk) begin
		if (kb_we) kb_mem[wc_q[KI-1:0]] <= in_data.key_word;
		kb_rd_q <= kb_mem[kb_ra];
		if (val_we) val_mem[val_wa] <= val_wd;
		val_rd_q <= val_mem[slot_q];
		if (ent_we) begin
			len_mem[fslot_q] <= n_q;
			hdl_mem[fslot_q] <= hdl_in_q;
		end
		len_rd_q <= len_mem[slot_q];
		hdl_rd_q <= hdl_mem[slot_q];
		if (key_we) key_mem[fbase_q + KAW'(j_q)] <= kb_rd_q;
		key_rd_q <= key_mem[wbase_q + KAW'(j_q)];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pkhc_pkg::S_CLEAR;
			clr_q       <= '0;
			wc_q        <= '0;
			tl_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pkhc_pkg::S_CLEAR) clr_q <= clr_q + SW'(1);
			if (in_acc) begin
				if (in_data.last_word) begin
					wc_q <= '0;
					tl_q <= 1'b0;
				end else if (room) begin
					wc_q <= wc_q + LW'(1);
				end else begin
					tl_q <= 1'b1;
				end
			end
			if (state_q == pkhc_pkg::S_RESULT && state_d == pkhc_pkg::S_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pkhc_pkg::S_IDLE: begin
				if (last_acc) begin
					n_q      <= n_new;
					op_q     <= in_data.opcode;
					hdl_in_q <= in_data.entry_value;
					mod_q    <= mod_eff;
					i_q      <= '0;
					a_q      <= pkhc_pkg::JH_INIT_SEED + {30'(n_new), 2'b00};
					b_q      <= pkhc_pkg::JH_INIT_SEED + {30'(n_new), 2'b00};
					c_q      <= pkhc_pkg::JH_INIT_SEED + {30'(n_new), 2'b00};
					status_q <= pkhc_pkg::ST_TOO_LONG;
					val_q    <= '0;
				end
			end
			pkhc_pkg::S_HCHK: begin
				k_q    <= '0;
				r_q    <= '0;
				dcnt_q <= 5'd31;
			end
			pkhc_pkg::S_HADD: begin
				case (k_q)
					2'd0: a_q <= a_q + kb_rd_q;
					2'd1: b_q <= b_q + kb_rd_q;
					default: c_q <= c_q + kb_rd_q;
				endcase
				k_q    <= k_q + 2'd1;
				step_q <= '0;
				ph_q   <= '0;
			end
			pkhc_pkg::S_HMIX, pkhc_pkg::S_HFIN: begin
				a_q    <= a_n;
				b_q    <= b_n;
				c_q    <= c_n;
				step_q <= step_q + 3'd1;
				ph_q   <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
				if (state_q == pkhc_pkg::S_HMIX && step_q == 3'd5) i_q <= i_q + LW'(3);
				r_q    <= '0;
				dcnt_q <= 5'd31;
			end
			pkhc_pkg::S_DIV: begin
				r_q    <= r_n;
				c_q    <= {c_q[30:0], 1'b0};
				dcnt_q <= dcnt_q - 5'd1;
			end
			pkhc_pkg::S_BASE: begin
				slot_q  <= SW'(int'(r_q) * WAYS);
				wbase_q <= KAW'(int'(r_q) * (WAYS * MAX_PATH));
				w_q     <= '0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end
			pkhc_pkg::S_WCHK: begin
				j_q <= '0;
				if (!val_rd_q && !free_q) begin
					free_q  <= 1'b1;
					fslot_q <= slot_q;
					fbase_q <= wbase_q;
				end
				if (!len_eq && !last_way) begin
					w_q     <= w_q + WW'(1);
					slot_q  <= slot_q + SW'(1);
					wbase_q <= wbase_q + KAW'(MAX_PATH);
				end
			end
			pkhc_pkg::S_KCMP: begin
				if (key_rd_q != kb_rd_q) begin
					if (!last_way) begin
						w_q     <= w_q + WW'(1);
						slot_q  <= slot_q + SW'(1);
						wbase_q <= wbase_q + KAW'(MAX_PATH);
					end
				end else if (last_j) begin
					hit_q <= 1'b1;
					val_q <= hdl_rd_q;
				end else begin
					j_q <= j_q + LW'(1);
				end
			end
			pkhc_pkg::S_DECIDE: begin
				j_q <= '0;
				if (op_q == pkhc_pkg::OP_LOOKUP) begin
					status_q <= hit_q ? pkhc_pkg::ST_FOUND : pkhc_pkg::ST_NOT_FOUND;
					if (!hit_q) val_q <= '0;
				end else begin
					val_q <= '0;
					if (hit_q) begin
						status_q <= pkhc_pkg::ST_PRESENT;
					end else if (!free_q) begin
						status_q <= pkhc_pkg::ST_FULL;
					end else begin
						status_q <= pkhc_pkg::ST_INSERTED;
					end
				end
			end
			pkhc_pkg::S_CPWR: j_q <= j_q + LW'(1);
			pkhc_pkg::S_RESULT: begin
				if (state_d == pkhc_pkg::S_IDLE) begin
					out_q.status      <= status_q;
					out_q.found_value <= val_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= LW'(MAX_PATH))
		else $error("word count past MAX_PATH");

	a_way_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkhc_pkg::S_WCHK) |-> (32'(w_q) < 32'(WAYS)))
		else $error("way index out of range");

	a_mod_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkhc_pkg::S_BASE) |-> (r_q < mod_q))
		else $error("bucket not below modulus");

	a_val_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != pkhc_pkg::ST_FOUND) |-> (out_data.found_value == '0))
		else $error("value set on non-found status");

	a_ins_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkhc_pkg::S_INS) |-> (free_q && !hit_q && op_q == pkhc_pkg::OP_INSERT))
		else $error("insert without free way");

endmodule
